/* rtl/core/pink_noise_generator_defines.svh */
// assertion macros for the pink noise generator checks
`ifndef PINK_NOISE_GENERATOR_DEFINES_SVH
`define PINK_NOISE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PNG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pink noise check failed");

// next-cycle implication, disabled while reset is low
`define PNG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pink noise check failed");

`endif

/* rtl/core/png_pkg.sv */
package png_pkg;

    // generator state widths
    typedef logic [31:0]        t_lfsr;
    typedef logic [18:0]        t_octave;   // increment/decrement words, bits above 18 never set
    typedef logic signed [31:0] t_integ;
    typedef logic signed [20:0] t_coef;
    typedef logic signed [25:0] t_sample;

    localparam t_lfsr   BASE_SEED    = 32'h5EED41F5;
    localparam t_lfsr   LFSR_TAPS    = 32'h46000001;
    localparam t_octave BALANCE_INIT = 19'h4CCCC;

    localparam t_sample SAMPLE_MAX = 26'sh1FFFFFF;
    localparam t_sample SAMPLE_MIN = 26'sh2000000;

    // fir coefficients in q22 units, 0.0625 * c * 2^22 rounded
    localparam t_coef COEF_A [6] = '{21'sd312100, 21'sd42619, 21'sd579,
                                     21'sd6678, -21'sd399, 21'sd1919};
    localparam t_coef COEF_B [6] = '{21'sd465, 21'sd1187, -21'sd409,
                                     21'sd203, -21'sd127, 21'sd529};

    // lowest set bit mapped to octave weight: bit0 -> 8 ... bit3 -> 1
    function automatic logic [3:0] low_weight(input logic [3:0] v);
        logic [3:0] w;
        if (v[0])      w = 4'd8;
        else if (v[1]) w = 4'd4;
        else if (v[2]) w = 4'd2;
        else if (v[3]) w = 4'd1;
        else           w = 4'd0;
        return w;
    endfunction

    // mask used at step zero of a frame (bit-reversed octave order)
    function automatic t_octave frame_mask(input logic [7:0] frame);
        t_octave m;
        if (frame[3:0] != 4'd0) m = {4'b0, low_weight(frame[3:0]), 11'b0};
        else                    m = {8'b0, low_weight(frame[7:4]), 7'b0};
        return m;
    endfunction

    // signed sum of six coefficients, sign picked by index bits
    function automatic t_coef fir_lookup(input t_coef c [6], input logic [5:0] idx);
        t_coef acc;
        acc = '0;
        for (int k = 0; k < 6; k++) begin
            if (idx[k]) acc = acc + c[k];
            else        acc = acc - c[k];
        end
        return acc;
    endfunction

endpackage

/* rtl/core/pink_noise_generator.sv */
// pink noise generator, one sample per advance transaction
//
// channels: input transaction i_in_valid/o_in_ready carries i_advance. with
// advance high the generator steps once and queues one o_sample on the
// o_out_valid/i_out_ready channel; with advance low the transaction is
// taken and nothing changes. config channel i_cfg_valid/o_cfg_ready loads
// the lfsr with 0x5EED41F5 + i_cfg_seed, is always ready, and is meant to be
// used only while the generator is idle.
// output register: the sample shows in the cycle after its input transaction.
// throughput: one input transaction per cycle unless stalled; the whole step
// (lfsr shift, octave mask, integrator add, two 64-entry fir lookups and
// saturation) is one combinational pass between state and output registers.
// stall: the output register holds the sample while i_out_ready is low;
// o_in_ready drops only when that register is full and not being drained.
// reset (synchronous, active low): lfsr = 0x5EED41F5, both octave words =
// 0x4CCCC, integrator, frame and step counters cleared, output empty.
module pink_noise_generator
    import png_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic signed [31:0]  i_cfg_seed,
    // input
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_advance,
    // output
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [25:0]  o_sample
);

    // generator state
    t_lfsr      r_lfsr,  n_lfsr;
    t_octave    r_inc,   n_inc;
    t_octave    r_dec,   n_dec;
    t_integ     r_integ, n_integ;
    logic [7:0] r_frame, n_frame;
    logic [3:0] r_step,  n_step;

    // output register
    logic       r_out_valid, n_out_valid;
    t_sample    r_sample,    n_sample;

    logic              in_fire;
    logic              step_en;
    t_octave           mask;
    logic              rbit;
    logic signed [19:0] diff;
    t_coef             fir_a;
    t_coef             fir_b;
    logic signed [33:0] total;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign step_en     = in_fire && i_advance;

    always_comb begin
        // octave pick: first step of a frame uses the bit-reversed frame order
        if (r_step == 4'd0) begin
            mask    = frame_mask(r_frame);
            n_frame = r_frame + 8'd1;
        end else begin
            mask    = {low_weight(r_step), 15'b0};
            n_frame = r_frame;
        end
        rbit = r_lfsr[31];

        // old octave bit moves to decrement word, random bit toggles increment word
        n_dec   = (r_dec & ~mask) | (r_inc & mask);
        n_inc   = r_inc ^ (rbit ? mask : '0);
        diff    = $signed({1'b0, n_inc}) - $signed({1'b0, n_dec});
        n_integ = r_integ + {{12{diff[19]}}, diff};
        n_lfsr  = {r_lfsr[30:0], 1'b0} ^ (rbit ? LFSR_TAPS : '0);
        n_step  = r_step + 4'd1;

        // output uses integrator before update plus the fir of the new lfsr bits
        fir_a = fir_lookup(COEF_A, n_lfsr[5:0]);
        fir_b = fir_lookup(COEF_B, n_lfsr[11:6]);
        total = {{2{r_integ[31]}}, r_integ}
              + {{13{fir_a[20]}}, fir_a}
              + {{13{fir_b[20]}}, fir_b};

        // saturate to the 26-bit sample range
        if (total[33:25] == {9{total[33]}}) n_sample = total[25:0];
        else if (total[33])                 n_sample = SAMPLE_MIN;
        else                                n_sample = SAMPLE_MAX;

        if (step_en)          n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= BASE_SEED;
            r_inc       <= BALANCE_INIT;
            r_dec       <= BALANCE_INIT;
            r_integ     <= '0;
            r_frame     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (step_en) begin
                r_inc   <= n_inc;
                r_dec   <= n_dec;
                r_integ <= n_integ;
                r_frame <= n_frame;
                r_step  <= n_step;
            end
            // seed load wins over a step on the lfsr
            if (i_cfg_valid) begin
                r_lfsr <= BASE_SEED + i_cfg_seed;
            end else if (step_en) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_sample <= n_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

/* rtl/core/png_checker.sv */
`include "pink_noise_generator_defines.svh"

module png_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_advance,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [25:0] o_sample
);

    // an advance transaction always produces a sample the next cycle
    `PNG_ASSERT_NEXT(a_advance_gives_sample, i_in_valid && o_in_ready && i_advance, o_out_valid)
    // empty output register never back-pressures the input
    `PNG_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)
    // stalled sample stays presented
    `PNG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // stalled sample keeps its value
    `PNG_ASSERT_NEXT(a_sample_hold, o_out_valid && !i_out_ready, $stable(o_sample))

endmodule

bind pink_noise_generator png_checker u_png_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import png_pkg::*;

    // generator constants, kept here so the predictor stands on its own
    localparam logic [31:0] NOISE_SEED_BASE  = 32'h5EED41F5;
    localparam logic [31:0] OCTAVE_WORD_INIT = 32'h0004CCCC;
    localparam logic [31:0] FEEDBACK_TAPS    = 32'h46000001;
    // seed that makes the shift register all zeros, so the noise source stops
    localparam logic [31:0] ZERO_LFSR_SEED   = 32'hA112BE0B;
    localparam longint      SAMPLE_HI        = 33554431;
    localparam longint      SAMPLE_LO        = -33554432;

    localparam int ITEMS_PER_PHASE = 205;
    localparam int SEED_PHASES     = 7;
    localparam int SETTLE_CYCLES   = 4;
    localparam int IDLE_LIMIT      = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_seed  = '0;
    logic        in_valid  = 1'b0;
    logic        advance   = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    t_sample     o_sample;

    pink_noise_generator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (cfg_seed),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_sample    (o_sample)
    );

    initial forever #4 clk = ~clk;

    // ------------------------------------------------------------------
    // noise predictor state
    // ------------------------------------------------------------------
    logic [31:0] gen_lfsr;
    logic [31:0] gen_inc;
    logic [31:0] gen_dec;
    int          gen_integ;
    logic [7:0]  gen_frame;
    logic [3:0]  gen_step;

    bit      pending_ticks[$];
    t_sample expected_samples[$];

    int mismatch_count = 0;
    int samples_checked = 0;
    int ticks_sent = 0;
    int holds_sent = 0;
    int seed_writes = 0;

    // lowest set bit picks the octave: bit0 -> 8, bit1 -> 4, bit2 -> 2, bit3 -> 1
    function automatic logic [3:0] octave_weight(input logic [3:0] v);
        if (v[0]) return 4'd8;
        if (v[1]) return 4'd4;
        if (v[2]) return 4'd2;
        if (v[3]) return 4'd1;
        return 4'd0;
    endfunction

    // twelve fir taps in q22 units, first six on lfsr[5:0], last six on lfsr[11:6]
    function automatic int fir_tap(input int k);
        case (k)
            0:  return 312100;
            1:  return 42619;
            2:  return 579;
            3:  return 6678;
            4:  return -399;
            5:  return 1919;
            6:  return 465;
            7:  return 1187;
            8:  return -409;
            9:  return 203;
            10: return -127;
            default: return 529;
        endcase
    endfunction

    function automatic int fir_sum(input int first, input logic [5:0] idx);
        int acc;
        acc = 0;
        for (int k = 0; k < 6; k++) begin
            if (idx[k]) acc += fir_tap(first + k);
            else        acc -= fir_tap(first + k);
        end
        return acc;
    endfunction

    // one tick of the generator: updates the state, returns the sample it emits
    function automatic t_sample next_noise_sample();
        logic [31:0] mask;
        logic [31:0] rand_bits;
        int          prior;
        longint      total;
        if (gen_step == 4'd0) begin
            // frame start: bit-reversed octave order from the frame counter
            if (gen_frame[3:0] != 4'd0) mask = {28'd0, octave_weight(gen_frame[3:0])} << 11;
            else                        mask = {28'd0, octave_weight(gen_frame[7:4])} << 7;
            gen_frame = gen_frame + 8'd1;
        end else begin
            mask = {28'd0, octave_weight(gen_step)} << 15;
        end
        gen_step  = gen_step + 4'd1;
        rand_bits = {32{gen_lfsr[31]}};
        gen_dec   = (gen_dec & ~mask) | (gen_inc & mask);
        gen_inc   = gen_inc ^ (rand_bits & mask);
        prior     = gen_integ;
        gen_integ = gen_integ + int'(gen_inc) - int'(gen_dec);
        gen_lfsr  = {gen_lfsr[30:0], 1'b0} ^ (rand_bits & FEEDBACK_TAPS);
        // output uses the integrator from before this tick plus the fir on the new lfsr
        total = longint'(prior) + longint'(fir_sum(0, gen_lfsr[5:0]))
              + longint'(fir_sum(6, gen_lfsr[11:6]));
        if (total > SAMPLE_HI) total = SAMPLE_HI;
        if (total < SAMPLE_LO) total = SAMPLE_LO;
        return total[25:0];
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            advance    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ticks.size() != 0) begin
                in_valid <= 1'b1;
                advance  <= pending_ticks.pop_front();
                if (burst_left <= 1) begin
                    // now and then a long burst with no gap at all
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left <= $urandom_range(64, 200);
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= $urandom_range(0, 6);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: rotating ready pattern, reshuffled once pattern_left has counted out its cycles
    // ------------------------------------------------------------------
    logic [31:0] stall_pattern = '1;
    int          pattern_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready    <= 1'b0;
            stall_pattern <= '1;
            pattern_left <= 0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= '1;                    // always ready
                    1:       stall_pattern <= $urandom();            // random pattern
                    2:       stall_pattern <= 32'h11111111;          // sparse ready, one bit set per nibble
                    default: stall_pattern <= $urandom() | $urandom(); // mostly ready
                endcase
                pattern_left <= $urandom_range(16, 96);
            end else begin
                stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
                pattern_left  <= pattern_left - 1;
            end
            out_ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted ticks, checks accepted samples
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_sample want;
        if (!rst_n) begin
            gen_lfsr  = NOISE_SEED_BASE;
            gen_inc   = OCTAVE_WORD_INIT;
            gen_dec   = OCTAVE_WORD_INIT;
            gen_integ = 0;
            gen_frame = '0;
            gen_step  = '0;
        end else begin
            // seed write reloads only the shift register
            if (cfg_valid && o_cfg_ready) begin
                gen_lfsr = NOISE_SEED_BASE + cfg_seed;
                seed_writes++;
            end
            if (in_valid && o_in_ready) begin
                if (advance) begin
                    expected_samples.push_back(next_noise_sample());
                    ticks_sent++;
                end else begin
                    holds_sent++;
                end
            end
            if (o_out_valid && out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: sample %0d with no tick waiting", $time, o_sample);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    samples_checked++;
                    if (o_sample !== want) begin
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, want, o_sample);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no transaction on any channel for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // checked on falling edges, where every clocked update has settled
    task automatic wait_until_drained();
        do @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        logic [31:0] next_seed;
        int          queued;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first ticks from reset state, held ticks alone and back to back,
        // then sixteen more ticks, covering every step value of a frame
        pending_ticks = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        repeat (16) pending_ticks.push_back(1'b1);

        // each phase starts from a drained generator, so the sender pauses here
        for (int phase = 0; phase < SEED_PHASES; phase++) begin
            wait_until_drained();
            case (phase)
                0:       next_seed = 32'h7FFFFFFF;
                1:       next_seed = 32'h80000000;
                2:       next_seed = 32'hFFFFFFFF;
                3:       next_seed = ZERO_LFSR_SEED;
                4, 5:    next_seed = $urandom();
                default: next_seed = 32'h00000000;
            endcase
            @(posedge clk);
            cfg_seed  <= next_seed;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!o_cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            @(negedge clk);

            // mostly ticks, with a sprinkling of held transactions
            queued = 0;
            while (queued < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_ticks.push_back(1'b0);
                end else begin
                    pending_ticks.push_back(1'b1);
                end
                queued++;
            end
        end

        wait_until_drained();
        $display("covered %0d ticks and %0d held transactions across %0d seed writes",
                 ticks_sent, holds_sent, seed_writes);
        $display("compared %0d samples, %0d mismatches", samples_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
